// ===== hw/rtl/tga_pkg.sv =====
package tga_pkg;

   localparam int MAX_RESULTS = 3;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] DEPTH_RGB  = 8'd24;
   localparam logic [7:0] DEPTH_RGBA = 8'd32;

   // header byte positions
   localparam logic [4:0] POS_SIG_LAST  = 5'd11;
   localparam logic [4:0] POS_WIDTH_LO  = 5'd12;
   localparam logic [4:0] POS_WIDTH_HI  = 5'd13;
   localparam logic [4:0] POS_HEIGHT_LO = 5'd14;
   localparam logic [4:0] POS_HEIGHT_HI = 5'd15;
   localparam logic [4:0] POS_DEPTH     = 5'd16;
   localparam logic [4:0] POS_DESC      = 5'd17;

   localparam logic [3:0] SIG_TYPE_POS  = 4'd2;
   localparam logic [7:0] SIG_TYPE_BYTE = 8'h02;

   typedef enum logic [1:0] {
      PHASE_SIG,
      PHASE_HDR,
      PHASE_PIX,
      PHASE_IDLE
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_PIXEL,
      STATUS_HEADER_OK,
      STATUS_BAD_SIG,
      STATUS_BAD_SIZE
   } status_type;

   typedef struct packed {
      logic [7:0]  pixel_byte;
      status_type  status;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        has_alpha;
      logic        last_of_run;
      logic        image_done;
   } result_type;

   typedef struct packed {
      logic [CNT_W-1:0]                 count;
      result_type [MAX_RESULTS-1:0]     items;
   } push_type;

   // expected signature byte: uncompressed true-color, everything else zero
   function automatic logic [7:0] sig_byte(input logic [3:0] pos);
      logic [7:0] value;
      case (pos)
         SIG_TYPE_POS: value = SIG_TYPE_BYTE;
         default:      value = 8'h00;
      endcase
      return value;
   endfunction

endpackage

// ===== hw/rtl/tga_channel_if.sv =====
interface tga_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_file;

   modport source(output valid, output data_byte, output start_of_file, input ready);
   modport sink(input valid, input data_byte, input start_of_file, output ready);
endinterface

interface tga_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  pixel_byte;
   logic [1:0]  status;
   logic [15:0] image_width;
   logic [15:0] image_height;
   logic        has_alpha;
   logic        last_of_run;
   logic        image_done;

   modport source(output valid, output pixel_byte, output status, output image_width,
                  output image_height, output has_alpha, output last_of_run,
                  output image_done, input ready);
   modport sink(input valid, input pixel_byte, input status, input image_width,
                input image_height, input has_alpha, input last_of_run,
                input image_done, output ready);
endinterface

// ===== hw/rtl/tga_truecolor_stream_decoder.sv =====
// channel   dir  handshake      payload
// req_ch    in   valid/ready    data_byte, start_of_file
// rsp_ch    out  valid/ready    pixel_byte, status, image_width, image_height,
//                               has_alpha, last_of_run, image_done
//
// one input byte per cycle while req_ch.ready is high; results leave one per cycle while rsp_ch.ready is high
// a third pixel byte makes three results, all written into a four-entry queue at once
// results of an item are registered into the queue and show on rsp_ch once earlier results have left
// req_ch.ready drops only when the queue cannot hold the worst-case run of the next item
// synchronous reset clears parser state and empties the queue
module tga_truecolor_stream_decoder (
   input logic       clock,
   input logic       reset,
   tga_req_if.sink   req_ch,
   tga_rsp_if.source rsp_ch
);
   import tga_pkg::*;

   logic               accept;
   logic               pop;
   push_type           push;
   logic [CNT_W-1:0]   need;
   result_type         head;
   logic [LEVEL_W-1:0] level;
   logic [LEVEL_W:0]   room_sum;

   assign room_sum     = (LEVEL_W + 1)'(level) + (LEVEL_W + 1)'(need);
   assign req_ch.ready = room_sum <= (LEVEL_W + 1)'(QUEUE_DEPTH);
   assign accept       = req_ch.valid && req_ch.ready;
   assign pop          = rsp_ch.valid && rsp_ch.ready;

   tga_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_ch.data_byte),
      .start_of_file (req_ch.start_of_file),
      .push          (push),
      .need          (need)
   );

   tga_rsp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .level (level)
   );

   assign rsp_ch.valid        = level != LEVEL_W'(0);
   assign rsp_ch.pixel_byte   = head.pixel_byte;
   assign rsp_ch.status       = head.status;
   assign rsp_ch.image_width  = head.image_width;
   assign rsp_ch.image_height = head.image_height;
   assign rsp_ch.has_alpha    = head.has_alpha;
   assign rsp_ch.last_of_run  = head.last_of_run;
   assign rsp_ch.image_done   = head.image_done;

endmodule

// ===== hw/rtl/tga_parser.sv =====
module tga_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic                 start_of_file,
   output tga_pkg::push_type    push,
   output logic [tga_pkg::CNT_W-1:0] need
);
   import tga_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [4:0]  hpos_ff, hpos_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [7:0]  depth_ff, depth_in;
   logic        sig_ok_ff, sig_ok_in;
   logic [7:0]  held_ff [2];
   logic [7:0]  held_in [2];
   logic [1:0]  bip_ff, bip_in;
   logic [31:0] left_ff, left_in;

   phase_type   cur_phase;
   logic [4:0]  cur_hpos;
   logic [15:0] cur_width, cur_height;
   logic [7:0]  cur_depth;
   logic        cur_sig_ok;
   logic [1:0]  cur_bip;
   logic [31:0] cur_left;

   logic [15:0] width_new, height_new;
   logic [7:0]  depth_new;
   logic        sig_ok_new, sig_end, hdr_end, size_bad, is_rgba, pix_done, pix_end;
   logic [31:0] left_dec, area;
   push_type    push_c;
   result_type  base;

   // start of file clears the parser before this byte is taken
   assign cur_phase  = start_of_file ? PHASE_SIG : phase_ff;
   assign cur_hpos   = start_of_file ? 5'd0 : hpos_ff;
   assign cur_width  = start_of_file ? 16'd0 : width_ff;
   assign cur_height = start_of_file ? 16'd0 : height_ff;
   assign cur_depth  = start_of_file ? 8'd0 : depth_ff;
   assign cur_sig_ok = start_of_file | sig_ok_ff;
   assign cur_bip    = start_of_file ? 2'd0 : bip_ff;
   assign cur_left   = start_of_file ? 32'd0 : left_ff;

   assign width_new  = (cur_phase == PHASE_HDR && cur_hpos == POS_WIDTH_LO)
                       ? {cur_width[15:8], data_byte}
                       : (cur_phase == PHASE_HDR && cur_hpos == POS_WIDTH_HI)
                       ? {data_byte, cur_width[7:0]} : cur_width;
   assign height_new = (cur_phase == PHASE_HDR && cur_hpos == POS_HEIGHT_LO)
                       ? {cur_height[15:8], data_byte}
                       : (cur_phase == PHASE_HDR && cur_hpos == POS_HEIGHT_HI)
                       ? {data_byte, cur_height[7:0]} : cur_height;
   assign depth_new  = (cur_phase == PHASE_HDR && cur_hpos == POS_DEPTH)
                       ? data_byte : cur_depth;

   assign sig_ok_new = cur_sig_ok & (data_byte == sig_byte(cur_hpos[3:0]));
   assign sig_end    = cur_hpos >= POS_SIG_LAST;
   assign hdr_end    = cur_hpos >= POS_DESC;
   assign size_bad   = (width_new == 16'd0) || (height_new == 16'd0) ||
                       ((depth_new != DEPTH_RGB) && (depth_new != DEPTH_RGBA));
   assign is_rgba    = cur_depth == DEPTH_RGBA;
   assign left_dec   = cur_left - 32'd1;
   assign pix_done   = left_dec == 32'd0;
   assign pix_end    = (cur_bip == 2'd2 && !is_rgba) || (cur_bip == 2'd3);
   assign area       = 32'(width_new) * 32'(height_new);

   // worst-case result count of the next item, from registered state
   assign need = (phase_ff == PHASE_PIX && bip_ff == 2'd2) ? CNT_W'(MAX_RESULTS) : CNT_W'(1);

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         phase_in = cur_phase;
         unique case (cur_phase)
            PHASE_SIG: begin
               if (sig_end) begin
                  phase_in = sig_ok_new ? PHASE_HDR : PHASE_IDLE;
               end
            end
            PHASE_HDR: begin
               if (hdr_end) begin
                  phase_in = size_bad ? PHASE_IDLE : PHASE_PIX;
               end
            end
            PHASE_PIX: begin
               if (pix_end && pix_done) begin
                  phase_in = PHASE_IDLE;
               end
            end
            default: phase_in = cur_phase;
         endcase
      end
   end

   always_comb begin
      hpos_in   = hpos_ff;
      width_in  = width_ff;
      height_in = height_ff;
      depth_in  = depth_ff;
      sig_ok_in = sig_ok_ff;
      held_in   = held_ff;
      bip_in    = bip_ff;
      left_in   = left_ff;
      push_c    = '0;
      base.pixel_byte   = 8'd0;
      base.status       = STATUS_PIXEL;
      base.image_width  = width_new;
      base.image_height = height_new;
      base.has_alpha    = depth_new == DEPTH_RGBA;
      base.last_of_run  = 1'b0;
      base.image_done   = 1'b0;
      if (accept) begin
         hpos_in   = cur_hpos;
         width_in  = width_new;
         height_in = height_new;
         depth_in  = depth_new;
         sig_ok_in = cur_sig_ok;
         bip_in    = cur_bip;
         left_in   = cur_left;
         unique case (cur_phase)
            PHASE_SIG: begin
               sig_ok_in = sig_ok_new;
               if (sig_end) begin
                  hpos_in = POS_WIDTH_LO;
                  if (!sig_ok_new) begin
                     push_c.count                = CNT_W'(1);
                     push_c.items[0]             = base;
                     push_c.items[0].status      = STATUS_BAD_SIG;
                     push_c.items[0].last_of_run = 1'b1;
                  end
               end else begin
                  hpos_in = cur_hpos + 5'd1;
               end
            end
            PHASE_HDR: begin
               if (hdr_end) begin
                  push_c.count                = CNT_W'(1);
                  push_c.items[0]             = base;
                  push_c.items[0].last_of_run = 1'b1;
                  if (size_bad) begin
                     push_c.items[0].status = STATUS_BAD_SIZE;
                  end else begin
                     push_c.items[0].status = STATUS_HEADER_OK;
                     bip_in  = 2'd0;
                     left_in = area;
                  end
               end else begin
                  hpos_in = cur_hpos + 5'd1;
               end
            end
            PHASE_PIX: begin
               if (cur_bip < 2'd2) begin
                  held_in[cur_bip[0]] = data_byte;
                  bip_in = cur_bip + 2'd1;
               end else if (cur_bip == 2'd2) begin
                  push_c.count                = CNT_W'(MAX_RESULTS);
                  push_c.items[0]             = base;
                  push_c.items[0].pixel_byte  = data_byte;
                  push_c.items[1]             = base;
                  push_c.items[1].pixel_byte  = held_ff[1];
                  push_c.items[2]             = base;
                  push_c.items[2].pixel_byte  = held_ff[0];
                  push_c.items[2].last_of_run = 1'b1;
                  if (is_rgba) begin
                     bip_in = 2'd3;
                  end else begin
                     bip_in  = 2'd0;
                     left_in = left_dec;
                     push_c.items[2].image_done = pix_done;
                  end
               end else begin
                  bip_in  = 2'd0;
                  left_in = left_dec;
                  push_c.count                = CNT_W'(1);
                  push_c.items[0]             = base;
                  push_c.items[0].pixel_byte  = data_byte;
                  push_c.items[0].last_of_run = 1'b1;
                  push_c.items[0].image_done  = pix_done;
               end
            end
            default: ;
         endcase
      end
   end

   assign push = push_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_SIG;
         hpos_ff   <= 5'd0;
         width_ff  <= 16'd0;
         height_ff <= 16'd0;
         depth_ff  <= 8'd0;
         sig_ok_ff <= 1'b1;
         bip_ff    <= 2'd0;
         left_ff   <= 32'd0;
      end else begin
         phase_ff  <= phase_in;
         hpos_ff   <= hpos_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         depth_ff  <= depth_in;
         sig_ok_ff <= sig_ok_in;
         bip_ff    <= bip_in;
         left_ff   <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   a_run_size: assert property (@(posedge clock) disable iff (reset)
      (push.count == CNT_W'(0) || push.count == CNT_W'(1) ||
       push.count == CNT_W'(MAX_RESULTS)))
      else $error("illegal result run size");

   a_run_last: assert property (@(posedge clock) disable iff (reset)
      (push.count == CNT_W'(MAX_RESULTS)) |->
         (push.items[2].last_of_run && !push.items[0].last_of_run &&
          !push.items[1].last_of_run))
      else $error("last_of_run misplaced in pixel run");

   a_done_ends_image: assert property (@(posedge clock) disable iff (reset)
      (accept && cur_phase == PHASE_PIX && phase_in == PHASE_IDLE) |->
         (push.items[0].image_done || push.items[2].image_done))
      else $error("image ended without image_done");

endmodule

// ===== hw/rtl/tga_rsp_queue.sv =====
module tga_rsp_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  tga_pkg::push_type            push,
   input  logic                         pop,
   output tga_pkg::result_type          head,
   output logic [tga_pkg::LEVEL_W-1:0]  level
);
   import tga_pkg::*;

   result_type         entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_W-1:0] level_ff, level_in;

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign level_in  = level_ff + LEVEL_W'(push.count) - LEVEL_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (CNT_W'(k) < push.count) begin
            entries_ff[wr_ptr_ff + PTR_W'(k)] <= push.items[k];
         end
      end
   end

   assign head  = entries_ff[rd_ptr_ff];
   assign level = level_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ((LEVEL_W + 1)'(level_ff) + (LEVEL_W + 1)'(push.count)) <=
      ((LEVEL_W + 1)'(QUEUE_DEPTH) + (LEVEL_W + 1)'(pop)))
      else $error("result queue overflow");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_W'(QUEUE_DEPTH))
      else $error("result queue level out of range");

endmodule

// ===== sim/tga_truecolor_stream_decoder_tb.sv =====
module tga_truecolor_stream_decoder_tb;
   import tga_pkg::*;

   localparam int CLOCK_HALF   = 2;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 300;
   localparam int IDLE_PCT     = 34;
   localparam int CALM_FIRST   = 600;
   localparam int CALM_LAST    = 900;
   localparam int HOLD_START   = 150;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic [7:0] data;
      logic       first;
   } file_byte_type;

   logic        clock;
   logic        reset;
   logic        calm;
   int unsigned cycle_count;
   int          fail_count;
   int          hold_left;

   file_byte_type file_bytes[$];
   file_byte_type offer;
   result_type    decoded_queue[$];

   // decoder state as seen by the checker
   phase_type   parse_phase;
   logic [4:0]  hdr_pos;
   logic [15:0] cap_width;
   logic [15:0] cap_height;
   logic [7:0]  cap_depth;
   logic        sig_match;
   logic [7:0]  held_b0;
   logic [7:0]  held_b1;
   logic [1:0]  byte_idx;
   logic [31:0] pixels_remaining;

   tga_req_if req_ch();
   tga_rsp_if rsp_ch();

   tga_truecolor_stream_decoder u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   assign calm = (cycle_count >= CALM_FIRST) && (cycle_count < CALM_LAST);

   function automatic void clear_parser();
      parse_phase      = PHASE_SIG;
      hdr_pos          = 5'd0;
      cap_width        = 16'd0;
      cap_height       = 16'd0;
      cap_depth        = 8'd0;
      sig_match        = 1'b1;
      held_b0          = 8'd0;
      held_b1          = 8'd0;
      byte_idx         = 2'd0;
      pixels_remaining = 32'd0;
   endfunction

   function automatic void push_result(input logic [7:0] pix, input status_type st,
                                       input logic last, input logic done);
      result_type r;
      r.pixel_byte   = pix;
      r.status       = st;
      r.image_width  = cap_width;
      r.image_height = cap_height;
      r.has_alpha    = (cap_depth == DEPTH_RGBA);
      r.last_of_run  = last;
      r.image_done   = done;
      decoded_queue.push_back(r);
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic first);
      logic       done;
      logic [7:0] sig_want;
      done = 1'b0;
      if (first) clear_parser();
      case (parse_phase)
         PHASE_SIG: begin
            sig_want = (hdr_pos == SIG_TYPE_POS) ? SIG_TYPE_BYTE : 8'h00;
            if (b != sig_want) sig_match = 1'b0;
            if (hdr_pos >= POS_SIG_LAST) begin
               hdr_pos = POS_WIDTH_LO;
               if (sig_match) begin
                  parse_phase = PHASE_HDR;
               end else begin
                  parse_phase = PHASE_IDLE;
                  push_result(8'h00, STATUS_BAD_SIG, 1'b1, 1'b0);
               end
            end else begin
               hdr_pos = hdr_pos + 5'd1;
            end
         end
         PHASE_HDR: begin
            case (hdr_pos)
               POS_WIDTH_LO:  cap_width[7:0]   = b;
               POS_WIDTH_HI:  cap_width[15:8]  = b;
               POS_HEIGHT_LO: cap_height[7:0]  = b;
               POS_HEIGHT_HI: cap_height[15:8] = b;
               POS_DEPTH:     cap_depth        = b;
               default: ;
            endcase
            if (hdr_pos >= POS_DESC) begin
               if (cap_width == 16'd0 || cap_height == 16'd0 ||
                   (cap_depth != DEPTH_RGB && cap_depth != DEPTH_RGBA)) begin
                  parse_phase = PHASE_IDLE;
                  push_result(8'h00, STATUS_BAD_SIZE, 1'b1, 1'b0);
               end else begin
                  parse_phase      = PHASE_PIX;
                  byte_idx         = 2'd0;
                  pixels_remaining = {16'd0, cap_width} * {16'd0, cap_height};
                  push_result(8'h00, STATUS_HEADER_OK, 1'b1, 1'b0);
               end
            end else begin
               hdr_pos = hdr_pos + 5'd1;
            end
         end
         PHASE_PIX: begin
            if (byte_idx == 2'd0) begin
               held_b0  = b;
               byte_idx = 2'd1;
            end else if (byte_idx == 2'd1) begin
               held_b1  = b;
               byte_idx = 2'd2;
            end else if (byte_idx == 2'd2) begin
               if (cap_depth == DEPTH_RGBA) begin
                  byte_idx = 2'd3;
               end else begin
                  pixels_remaining = pixels_remaining - 32'd1;
                  byte_idx         = 2'd0;
                  if (pixels_remaining == 32'd0) begin
                     done        = 1'b1;
                     parse_phase = PHASE_IDLE;
                  end
               end
               push_result(b, STATUS_PIXEL, 1'b0, 1'b0);
               push_result(held_b1, STATUS_PIXEL, 1'b0, 1'b0);
               push_result(held_b0, STATUS_PIXEL, 1'b1, done);
            end else begin
               pixels_remaining = pixels_remaining - 32'd1;
               byte_idx         = 2'd0;
               if (pixels_remaining == 32'd0) begin
                  done        = 1'b1;
                  parse_phase = PHASE_IDLE;
               end
               push_result(b, STATUS_PIXEL, 1'b1, done);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void add_byte(input logic [7:0] d, input logic first);
      file_byte_type fb;
      fb.data  = d;
      fb.first = first;
      file_bytes.push_back(fb);
   endfunction

   function automatic void add_random_bytes(input int n);
      for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)), 1'b0);
   endfunction

   // bad_pos < 0 gives a clean signature
   function automatic void add_signature(input logic first, input int bad_pos);
      logic [7:0] sig;
      for (int i = 0; i < 12; i++) begin
         sig = (i == SIG_TYPE_POS) ? SIG_TYPE_BYTE : 8'h00;
         if (i == bad_pos) sig = sig ^ 8'($urandom_range(1, 255));
         add_byte(sig, first && (i == 0));
      end
   endfunction

   function automatic void add_size(input logic [15:0] w, input logic [15:0] h,
                                    input logic [7:0] depth);
      add_byte(w[7:0], 1'b0);
      add_byte(w[15:8], 1'b0);
      add_byte(h[7:0], 1'b0);
      add_byte(h[15:8], 1'b0);
      add_byte(depth, 1'b0);
      add_byte(8'($urandom_range(0, 255)), 1'b0);
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void check_result();
      result_type want;
      if (decoded_queue.size() == 0) begin
         $error("unexpected item: pixel_byte %0h status %0d", rsp_ch.pixel_byte, rsp_ch.status);
         fail_count++;
         return;
      end
      want = decoded_queue.pop_front();
      check_field("pixel_byte", 16'(want.pixel_byte), 16'(rsp_ch.pixel_byte));
      check_field("status", 16'(want.status), 16'(rsp_ch.status));
      check_field("image_width", want.image_width, rsp_ch.image_width);
      check_field("image_height", want.image_height, rsp_ch.image_height);
      check_field("has_alpha", 16'(want.has_alpha), 16'(rsp_ch.has_alpha));
      check_field("last_of_run", 16'(want.last_of_run), 16'(rsp_ch.last_of_run));
      check_field("image_done", 16'(want.image_done), 16'(rsp_ch.image_done));
   endfunction

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) decode_byte(req_ch.data_byte, req_ch.start_of_file);
         if (file_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
            offer = file_bytes.pop_front();
            req_ch.valid         <= 1'b1;
            req_ch.data_byte     <= offer.data;
            req_ch.start_of_file <= offer.first;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor, with one long hold-off so the block backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_result();
         if (cycle_count == HOLD_START) begin
            hold_left    <= HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      int         kind;
      int         w;
      int         h;
      int         bpp;
      int         n;
      int         base;
      int         ignored;
      logic [7:0] depth;
      logic       first;

      reset                = 1'b1;
      cycle_count          = 0;
      fail_count           = 0;
      req_ch.valid         = 1'b0;
      req_ch.data_byte     = 8'h00;
      req_ch.start_of_file = 1'b0;
      rsp_ch.ready         = 1'b0;
      clear_parser();

      // first file arrives without a start marker
      add_signature(1'b0, -1);
      add_size(16'd1, 16'd1, DEPTH_RGB);
      add_byte(8'h00, 1'b0);
      add_byte(8'hff, 1'b0);
      add_byte(8'h5a, 1'b0);
      // rgba image, then bytes past its end
      add_signature(1'b1, -1);
      add_size(16'd2, 16'd1, DEPTH_RGBA);
      add_random_bytes(10);
      add_signature(1'b1, SIG_TYPE_POS);
      add_signature(1'b1, -1);
      add_size(16'hffff, 16'd0, DEPTH_RGB);
      add_signature(1'b1, -1);
      add_size(16'd0, 16'hffff, DEPTH_RGBA);
      add_signature(1'b1, -1);
      add_size(16'd1, 16'd1, 8'd8);
      // huge image cut short, then a fresh file
      add_signature(1'b1, -1);
      add_size(16'hffff, 16'hffff, DEPTH_RGBA);
      add_random_bytes(5);
      add_signature(1'b1, -1);
      add_size(16'd1, 16'd2, DEPTH_RGB);
      add_random_bytes(6);

      base    = file_bytes.size();
      ignored = 0;
      while (file_bytes.size() - ignored < base + RANDOM_ITEMS) begin
         kind  = $urandom_range(0, 99);
         first = ($urandom_range(0, 9) != 0);
         w     = $urandom_range(1, 3);
         h     = $urandom_range(1, 3);
         depth = $urandom_range(0, 1) ? DEPTH_RGBA : DEPTH_RGB;
         bpp   = (depth == DEPTH_RGBA) ? 4 : 3;
         if (kind < 60) begin
            add_signature(first, -1);
            add_size(16'(w), 16'(h), depth);
            add_random_bytes(w * h * bpp);
            if ($urandom_range(0, 2) == 0) begin
               n = $urandom_range(1, 4);
               add_random_bytes(n);
               ignored += n;
            end
         end else if (kind < 70) begin
            add_signature(first, $urandom_range(0, 11));
         end else if (kind < 80) begin
            w     = $urandom_range(0, 65535);
            h     = $urandom_range(0, 65535);
            depth = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 2))
               0: w = 0;
               1: h = 0;
               default: begin
                  while (depth == DEPTH_RGB || depth == DEPTH_RGBA)
                     depth = 8'($urandom_range(0, 255));
               end
            endcase
            add_signature(first, -1);
            add_size(16'(w), 16'(h), depth);
         end else if (kind < 90) begin
            add_signature(first, -1);
            add_size(16'(w), 16'(h), depth);
            add_random_bytes($urandom_range(0, w * h * bpp - 1));
         end else begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
               add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (file_bytes.size() != 0 || req_ch.valid) @(negedge clock);
      while (decoded_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== tga_truecolor_stream_decoder.f =====
hw/rtl/tga_pkg.sv
hw/rtl/tga_channel_if.sv
hw/rtl/tga_parser.sv
hw/rtl/tga_rsp_queue.sv
hw/rtl/tga_truecolor_stream_decoder.sv
sim/tga_truecolor_stream_decoder_tb.sv
